@@ sv/hgt_pkg.sv @@
// Shared types and constants of the height grid triangulator.
package hgt_pkg;

    // Field widths
    localparam int COORD_W     = 32;
    localparam int IDX_W       = 20;
    localparam int ENTRY_W     = IDX_W + 1;
    localparam int CFG_COUNT_W = 11;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // Stream payload widths
    localparam int IN_TDATA_W  = 3 * COORD_W;
    localparam int OUT_FIELD_W = 3 * COORD_W + 3 * IDX_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_Z_LOW        = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_Z_HIGH       = CFG_INDEX_W'(3);

    // Result kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // Result slots of one sample, emitted lowest first
    localparam int SLOT_VERTEX = 0;
    localparam int SLOT_ABC    = 1;
    localparam int SLOT_ACB    = 2;
    localparam int SLOT_DCB    = 3;
    localparam int SLOT_DBC    = 4;
    localparam int SLOT_N      = 5;

    typedef logic [SLOT_N-1:0]         t_slots;
    typedef logic [IDX_W-1:0]          t_index;
    typedef logic signed [COORD_W-1:0] t_coord;

    // Line store entry: visible flag over compacted index
    typedef struct packed {
        logic   vis;
        t_index idx;
    } t_entry;

endpackage

@@ sv/hgt_ram.sv @@
// Generic single-port-write, registered-read RAM (read returns old data on collision).
module hgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/height_grid_triangulator.sv @@
// Height grid triangulator: top level with line store, cell stage and result sequencer.
// The first result of a sample passes the cell stage, sequencer and output registers.
// The output register gives one result per cycle while m_axis_tready is high; a sample
// holds the sequencer until its results (at most 5) are sent; one with none skips it.
// The line store reads and writes one entry per accepted sample (none if degenerate).
// Reset clears positions, counts and handshake state; the line store is not cleared.
module height_grid_triangulator #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hgt_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [hgt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: [31:0] sample_x, [63:32] sample_y, [95:64] sample_z
    input  logic [hgt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: [31:0] vertex_x, [63:32] vertex_y, [95:64] vertex_z,
    //        [115:96] corner_first, [135:116] corner_second,
    //        [155:136] corner_third, [159:156] zero
    output logic [hgt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // tuser: [0] kind
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    import hgt_pkg::*;

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CNT_W = ((CW > RW ? CW : RW) + 1 > CFG_COUNT_W) ?
                           (CW > RW ? CW : RW) + 1 : CFG_COUNT_W;

    // Configuration registers
    logic [CFG_COUNT_W-1:0] r_row_count;
    logic [CFG_COUNT_W-1:0] r_column_count;
    t_coord                 r_z_low;
    t_coord                 r_z_high;

    // Grid walk state
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    t_index        r_total, n_total;
    t_entry        r_left, n_left;

    logic cfg_we;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // Effective grid size, saturated to the store limits
    logic [CNT_W-1:0] cols_ext, rows_ext, cols_eff, rows_eff;
    assign cols_ext = CNT_W'(r_column_count);
    assign rows_ext = CNT_W'(r_row_count);
    assign cols_eff = (cols_ext > CNT_W'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : cols_ext;
    assign rows_eff = (rows_ext > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_ext;

    logic degenerate;
    assign degenerate = (cols_eff <= CNT_W'(1)) || (rows_eff <= CNT_W'(1));

    // Input fields
    t_coord in_x, in_y, in_z;
    assign in_x = s_axis_tdata[COORD_W-1:0];
    assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_z = s_axis_tdata[3*COORD_W-1:2*COORD_W];

    logic in_acc, in_live;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign in_live = in_acc && !degenerate;

    // Current position, restarting when left outside the grid
    logic          restart;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    t_index        cur_total;
    t_entry        cur_left;
    logic          in_vis;
    t_entry        cur_d;

    assign restart   = (CNT_W'(r_col) >= cols_eff) || (CNT_W'(r_row) >= rows_eff);
    assign cur_col   = restart ? '0 : r_col;
    assign cur_row   = restart ? '0 : r_row;
    assign cur_total = restart ? '0 : r_total;
    assign cur_left  = restart ? '0 : r_left;
    assign in_vis    = (in_z >= r_z_low) && (in_z <= r_z_high);
    assign cur_d     = '{vis: in_vis, idx: cur_total};

    // Next grid walk state
    logic [CNT_W-1:0] col_inc, row_inc;
    always_comb begin
        col_inc = CNT_W'(cur_col) + CNT_W'(1);
        row_inc = CNT_W'(cur_row) + CNT_W'(1);
        n_total = cur_total + IDX_W'(in_vis);
        n_left  = cur_d;
        n_col   = col_inc[CW-1:0];
        n_row   = cur_row;
        if (col_inc >= cols_eff) begin
            n_col = '0;
            n_row = row_inc[RW-1:0];
            if (row_inc >= rows_eff) begin
                n_row   = '0;
                n_total = '0;
                n_left  = '0;
            end
        end
    end

    // Hold configuration and advance the walk per accepted sample of a non-degenerate grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= '0;
            r_column_count <= '0;
            r_z_low        <= {1'b1, {(COORD_W-1){1'b0}}};
            r_z_high       <= {1'b0, {(COORD_W-1){1'b1}}};
            r_col          <= '0;
            r_row          <= '0;
            r_total        <= '0;
            r_left         <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data[CFG_COUNT_W-1:0];
                    r_col       <= '0;
                    r_row       <= '0;
                    r_total     <= '0;
                    r_left      <= '0;
                end
                CFG_COLUMN_COUNT: begin
                    r_column_count <= i_cfg_data[CFG_COUNT_W-1:0];
                    r_col          <= '0;
                    r_row          <= '0;
                    r_total        <= '0;
                    r_left         <= '0;
                end
                CFG_Z_LOW:  r_z_low  <= i_cfg_data[COORD_W-1:0];
                CFG_Z_HIGH: r_z_high <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end else if (in_live) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_total <= n_total;
            r_left  <= n_left;
        end
    end

    // Line store: read the upper entry and write this sample's entry at the same column
    logic [ENTRY_W-1:0] ram_q;
    hgt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (in_live),
        .i_waddr (cur_col),
        .i_wdata (cur_d),
        .i_re    (in_live),
        .i_raddr (cur_col),
        .o_rdata (ram_q)
    );

    // Cell stage registers
    logic   r_s1_valid;
    t_coord r_s1_x, r_s1_y, r_s1_z;
    t_entry r_s1_d, r_s1_c;
    logic   r_s1_cell, r_s1_row_gt0;
    t_entry r_upper_left;

    // Sequencer stage registers
    t_slots r_s2_mask;
    t_coord r_s2_x, r_s2_y, r_s2_z;
    t_index r_s2_ia, r_s2_ib, r_s2_ic, r_s2_id;

    // Output register
    logic                   r_out_valid;
    logic                   r_out_kind;
    logic                   r_out_last;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Decide which results the completed cell yields
    t_entry s1_b, s1_a;
    t_slots s1_mask;
    logic   abc_ok, bcd_ok;
    always_comb begin
        s1_b    = r_s1_row_gt0 ? t_entry'(ram_q) : '0;
        s1_a    = r_upper_left;
        abc_ok  = r_s1_cell && s1_a.vis && s1_b.vis && r_s1_c.vis;
        bcd_ok  = r_s1_cell && s1_b.vis && r_s1_c.vis && r_s1_d.vis;
        s1_mask = '0;
        s1_mask[SLOT_VERTEX] = r_s1_d.vis;
        s1_mask[SLOT_ABC]    = abc_ok;
        s1_mask[SLOT_ACB]    = abc_ok;
        s1_mask[SLOT_DCB]    = bcd_ok;
        s1_mask[SLOT_DBC]    = bcd_ok;
    end

    // Pick the next pending result of the sequencer
    t_slots s2_low, s2_rest;
    logic   out_load, s2_free, s1_go;
    logic   sel_kind;
    t_coord sel_x, sel_y, sel_z;
    t_index sel_c1, sel_c2, sel_c3;
    always_comb begin
        s2_low  = r_s2_mask & (~r_s2_mask + SLOT_N'(1));
        s2_rest = r_s2_mask & ~s2_low;
        sel_kind = KIND_TRIANGLE;
        sel_x    = '0;
        sel_y    = '0;
        sel_z    = '0;
        sel_c1   = '0;
        sel_c2   = '0;
        sel_c3   = '0;
        if (s2_low[SLOT_VERTEX]) begin
            sel_kind = KIND_VERTEX;
            sel_x    = r_s2_x;
            sel_y    = r_s2_y;
            sel_z    = r_s2_z;
        end else if (s2_low[SLOT_ABC]) begin
            sel_c1 = r_s2_ia;
            sel_c2 = r_s2_ib;
            sel_c3 = r_s2_ic;
        end else if (s2_low[SLOT_ACB]) begin
            sel_c1 = r_s2_ia;
            sel_c2 = r_s2_ic;
            sel_c3 = r_s2_ib;
        end else if (s2_low[SLOT_DCB]) begin
            sel_c1 = r_s2_id;
            sel_c2 = r_s2_ic;
            sel_c3 = r_s2_ib;
        end else begin
            sel_c1 = r_s2_id;
            sel_c2 = r_s2_ib;
            sel_c3 = r_s2_ic;
        end
    end

    assign out_load      = (r_s2_mask != '0) && (!r_out_valid || m_axis_tready);
    assign s2_free       = (r_s2_mask == '0) || (out_load && (s2_rest == '0));
    assign s1_go         = r_s1_valid && ((s1_mask == '0) || s2_free);
    assign s_axis_tready = !r_s1_valid || s1_go;

    // Cell stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= !degenerate;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Cell stage payload and upper-left corner
    always_ff @(posedge i_clk) begin
        if (in_live) begin
            r_s1_x       <= in_x;
            r_s1_y       <= in_y;
            r_s1_z       <= in_z;
            r_s1_d       <= cur_d;
            r_s1_c       <= cur_left;
            r_s1_cell    <= (cur_row != '0) && (cur_col != '0);
            r_s1_row_gt0 <= (cur_row != '0);
        end
        if (s1_go) begin
            r_upper_left <= s1_b;
        end
    end

    // Sequencer: load a new sample or drop the result just sent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mask <= '0;
        end else if (s1_go && (s1_mask != '0)) begin
            r_s2_mask <= s1_mask;
        end else if (out_load) begin
            r_s2_mask <= s2_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && (s1_mask != '0)) begin
            r_s2_x  <= r_s1_x;
            r_s2_y  <= r_s1_y;
            r_s2_z  <= r_s1_z;
            r_s2_ia <= s1_a.idx;
            r_s2_ib <= s1_b.idx;
            r_s2_ic <= r_s1_c.idx;
            r_s2_id <= r_s1_d.idx;
        end
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_kind <= sel_kind;
            r_out_last <= (s2_rest == '0);
            r_out_data <= OUT_TDATA_W'({sel_c3, sel_c2, sel_c1, sel_z, sel_y, sel_x});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule
